// ===== hdl/sle_pkg.sv =====
// ---------------------------------------------------------------------------
// sle_pkg: shared definitions for the scancode line editor
// Scancode codes, character codes, result codes, key maps and sizes.
// ---------------------------------------------------------------------------
package sle_pkg;

	localparam int LINE_CAPACITY = 64;
	localparam int HISTORY_DEPTH = 16;

	localparam int LINE_AW = $clog2(LINE_CAPACITY);
	localparam int HIST_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int HIST_WORDS = HISTORY_DEPTH * (2 ** LINE_AW);

	localparam int CHAR_W = 7;
	localparam int PADDR_W = 3;

	// scancodes
	localparam logic [7:0] SC_PREFIX  = 8'hE0;
	localparam logic [7:0] SC_LSHIFT  = 8'h2A;
	localparam logic [7:0] SC_RSHIFT  = 8'h36;
	localparam logic [7:0] SC_LSHIFT_R = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_R = 8'hB6;
	localparam logic [7:0] SC_CAPS    = 8'h3A;
	localparam logic [7:0] SC_LEFT    = 8'h4B;
	localparam logic [7:0] SC_RIGHT   = 8'h4D;
	localparam logic [7:0] SC_UP      = 8'h48;
	localparam logic [7:0] SC_DOWN    = 8'h50;
	localparam logic [7:0] SC_HOME    = 8'h47;
	localparam logic [7:0] SC_END     = 8'h4F;
	localparam logic [7:0] SC_DEL     = 8'h53;

	// characters with a meaning of their own
	localparam logic [6:0] CH_BS    = 7'd8;
	localparam logic [6:0] CH_LF    = 7'd10;
	localparam logic [6:0] CH_ESC   = 7'd27;
	localparam logic [6:0] CH_SPACE = 7'd32;
	localparam logic [6:0] CH_DEL   = 7'd127;
	localparam logic [6:0] CH_LOW_A = 7'h61;
	localparam logic [6:0] CH_LOW_Z = 7'h7A;

	// result codes
	localparam logic [2:0] EV_NONE   = 3'd0;
	localparam logic [2:0] EV_EDIT   = 3'd1;
	localparam logic [2:0] EV_CHAR   = 3'd2;
	localparam logic [2:0] EV_EMPTY  = 3'd3;
	localparam logic [2:0] EV_CANCEL = 3'd4;

	localparam logic [PADDR_W-1:0] ADDR_MAX_LINE = '0;

	localparam logic [6:0] PLAIN_MAP [64] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	localparam logic [6:0] UPPER_MAP [64] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_DECODE   = 9'b000000010,
		S_MV_RD    = 9'b000000100,
		S_MV_WR    = 9'b000001000,
		S_PUT      = 9'b000010000,
		S_LOAD     = 9'b000100000,
		S_EMIT_RD  = 9'b001000000,
		S_EMIT_OUT = 9'b010000000,
		S_RESP     = 9'b100000000
	} st_t;

	typedef enum logic [1:0] {
		M_LINE  = 2'd0,
		M_SAVED = 2'd1,
		M_HIST  = 2'd2
	} store_t;

endpackage

// ===== hdl/sle_ram.sv =====
// ---------------------------------------------------------------------------
// sle_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module sle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/scancode_line_editor_with_history.sv =====
// ---------------------------------------------------------------------------
// scancode_line_editor_with_history: set-1 scancode line editor
// Line editing with cursor, history ring browsing and line submission.
// ---------------------------------------------------------------------------
// One scancode word is taken at a time. Insert, Backspace and Delete move the
// characters behind the cursor one at a time through the line RAM. Up and Down
// copy whole lines between the line, saved-line and history RAMs, up to two
// copies per key. Enter copies a non-empty line into the history RAM, then
// sends one result word per character, waiting while the output is stalled.
// The output register lets the next scancode be taken while the last result
// waits.
module scancode_line_editor_with_history (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  scancode,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic [6:0]  character,
	output logic [5:0]  cursor_pos,
	output logic [5:0]  line_length,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [sle_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = sle_pkg::LINE_AW;
	localparam int HW = sle_pkg::HIST_AW;
	localparam int FW = sle_pkg::FILL_W;
	localparam int CW = sle_pkg::CHAR_W;

	sle_pkg::st_t    st_q, cont_q;
	sle_pkg::store_t src_q, dst_q;

	logic [7:0]    sc_q;
	logic [CW-1:0] ch_q;
	logic [2:0]    ev_q;
	logic [6:0]    max_line_q;
	logic [AW-1:0] count_q, cursor_q, saved_cnt_q;
	logic [FW-1:0] hfill_q;
	logic [HW-1:0] hhead_q, boff_q, slot_q;
	logic          browse_q, ext_q, shift_q, caps_q;
	logic [AW-1:0] hlen_q [sle_pkg::HISTORY_DEPTH];
	logic [AW-1:0] rd_idx_q, wr_idx_q, mv_cnt_q, emit_n_q;
	logic          mv_up_q;

	logic          out_valid_q, last_q;
	logic [2:0]    out_ev_q;
	logic [CW-1:0] out_ch_q;
	logic [AW-1:0] out_cur_q, out_len_q;

	logic          out_free;
	logic [6:0]    ml_c;
	logic [AW-1:0] lim_c;
	logic          up_c;
	logic [CW-1:0] plain_c, ch_c;
	logic [HW:0]   slot_sum_c;
	logic [HW-1:0] slot_c;
	logic [AW-1:0] hlen_sel_c, load_n_c, enter_n_c;
	logic [CW-1:0] line_rdata, saved_rdata, hist_rdata, mv_data;
	logic          line_we, saved_we, hist_we;
	logic [AW-1:0] line_waddr;
	logic [CW-1:0] line_wdata;
	logic          cfg_wr;

	// ---------------------------------------------------------------- config
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[sle_pkg::PADDR_W-1] == 1'b0);
	assign prdata = (paddr[sle_pkg::PADDR_W-1] == 1'b0) ? {25'd0, max_line_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_line_q <= 7'(sle_pkg::LINE_CAPACITY);
		end else if (cfg_wr) begin
			max_line_q <= pwdata[6:0];
		end
	end

	// ---------------------------------------------------------------- decode
	always_comb begin
		if (max_line_q < 7'd2) begin
			ml_c = 7'd2;
		end else if (max_line_q > 7'(sle_pkg::LINE_CAPACITY)) begin
			ml_c = 7'(sle_pkg::LINE_CAPACITY);
		end else begin
			ml_c = max_line_q;
		end
	end
	assign lim_c = AW'(ml_c - 7'd1);

	always_comb begin
		plain_c = sle_pkg::PLAIN_MAP[sc_q[5:0]];
		up_c = shift_q;
		if (caps_q && plain_c >= sle_pkg::CH_LOW_A && plain_c <= sle_pkg::CH_LOW_Z) begin
			up_c = !shift_q;
		end
		if (sc_q[7:6] != 2'b00) begin
			ch_c = '0;
		end else if (up_c) begin
			ch_c = sle_pkg::UPPER_MAP[sc_q[5:0]];
		end else begin
			ch_c = plain_c;
		end
	end

	// ring slot of the entry at the current browse offset
	always_comb begin
		slot_sum_c = {1'b0, hhead_q} + (HW+1)'(sle_pkg::HISTORY_DEPTH - 1) - {1'b0, boff_q};
		if (slot_sum_c >= (HW+1)'(sle_pkg::HISTORY_DEPTH)) begin
			slot_c = HW'(slot_sum_c - (HW+1)'(sle_pkg::HISTORY_DEPTH));
		end else begin
			slot_c = HW'(slot_sum_c);
		end
	end
	assign hlen_sel_c = hlen_q[slot_c];
	assign load_n_c   = (hlen_sel_c > lim_c) ? lim_c : hlen_sel_c;
	assign enter_n_c  = (count_q > lim_c) ? lim_c : count_q;

	// ---------------------------------------------------------------- memories
	always_comb begin
		case (src_q)
			sle_pkg::M_SAVED: mv_data = saved_rdata;
			sle_pkg::M_HIST:  mv_data = hist_rdata;
			default:          mv_data = line_rdata;
		endcase
	end

	assign line_we    = (st_q == sle_pkg::S_PUT) ||
		((st_q == sle_pkg::S_MV_WR) && (dst_q == sle_pkg::M_LINE));
	assign line_waddr = (st_q == sle_pkg::S_PUT) ? cursor_q : wr_idx_q;
	assign line_wdata = (st_q == sle_pkg::S_PUT) ? ch_q : mv_data;
	assign saved_we   = (st_q == sle_pkg::S_MV_WR) && (dst_q == sle_pkg::M_SAVED);
	assign hist_we    = (st_q == sle_pkg::S_MV_WR) && (dst_q == sle_pkg::M_HIST);

	sle_ram #(.WIDTH(CW), .DEPTH(2 ** AW)) u_line_ram (
		.clk   (clk),
		.we    (line_we),
		.waddr (line_waddr),
		.wdata (line_wdata),
		.raddr (rd_idx_q),
		.rdata (line_rdata)
	);

	sle_ram #(.WIDTH(CW), .DEPTH(2 ** AW)) u_saved_ram (
		.clk   (clk),
		.we    (saved_we),
		.waddr (wr_idx_q),
		.wdata (mv_data),
		.raddr (rd_idx_q),
		.rdata (saved_rdata)
	);

	sle_ram #(.WIDTH(CW), .DEPTH(sle_pkg::HIST_WORDS)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr ({slot_q, wr_idx_q}),
		.wdata (mv_data),
		.raddr ({slot_q, rd_idx_q}),
		.rdata (hist_rdata)
	);

	// ---------------------------------------------------------------- sequencer
	assign in_stall = (st_q != sle_pkg::S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= sle_pkg::S_IDLE;
			cont_q      <= sle_pkg::S_RESP;
			count_q     <= '0;
			cursor_q    <= '0;
			saved_cnt_q <= '0;
			hfill_q     <= '0;
			hhead_q     <= '0;
			boff_q      <= '0;
			browse_q    <= 1'b0;
			ext_q       <= 1'b0;
			shift_q     <= 1'b0;
			caps_q      <= 1'b0;
			mv_cnt_q    <= '0;
		end else begin
			unique case (st_q)
				sle_pkg::S_IDLE: begin
					if (in_valid) begin
						st_q <= sle_pkg::S_DECODE;
					end
				end
				sle_pkg::S_DECODE: begin
					st_q <= sle_pkg::S_RESP;
					if (sc_q == sle_pkg::SC_PREFIX) begin
						ext_q <= 1'b1;
					end else if (sc_q == sle_pkg::SC_LSHIFT || sc_q == sle_pkg::SC_RSHIFT) begin
						shift_q <= 1'b1;
					end else if (sc_q == sle_pkg::SC_LSHIFT_R ||
							sc_q == sle_pkg::SC_RSHIFT_R) begin
						shift_q <= 1'b0;
					end else if (sc_q == sle_pkg::SC_CAPS) begin
						caps_q <= !caps_q;
					end else if (sc_q[7]) begin
						ext_q <= 1'b0;
					end else if (ext_q) begin
						ext_q <= 1'b0;
						case (sc_q)
							sle_pkg::SC_LEFT: begin
								if (cursor_q != '0) begin
									cursor_q <= cursor_q - 1'b1;
								end
							end
							sle_pkg::SC_RIGHT: begin
								if (cursor_q < count_q) begin
									cursor_q <= cursor_q + 1'b1;
								end
							end
							sle_pkg::SC_HOME: cursor_q <= '0;
							sle_pkg::SC_END:  cursor_q <= count_q;
							sle_pkg::SC_DEL: begin
								if (cursor_q < count_q) begin
									// pull the tail left over the cursor
									mv_cnt_q <= count_q - cursor_q - 1'b1;
									count_q  <= count_q - 1'b1;
									cont_q   <= sle_pkg::S_RESP;
									if (count_q - cursor_q != AW'(1)) begin
										st_q <= sle_pkg::S_MV_RD;
									end
								end
							end
							sle_pkg::SC_UP: begin
								if (hfill_q != '0) begin
									if (!browse_q) begin
										browse_q    <= 1'b1;
										boff_q      <= '0;
										saved_cnt_q <= count_q;
										mv_cnt_q    <= count_q;
										cont_q      <= sle_pkg::S_LOAD;
										st_q <= (count_q == '0) ? sle_pkg::S_LOAD : sle_pkg::S_MV_RD;
									end else if ({1'b0, boff_q} < FW'(hfill_q - 1'b1)) begin
										boff_q <= boff_q + 1'b1;
										st_q   <= sle_pkg::S_LOAD;
									end
								end
							end
							sle_pkg::SC_DOWN: begin
								if (browse_q) begin
									if (boff_q == '0) begin
										browse_q <= 1'b0;
										count_q  <= saved_cnt_q;
										cursor_q <= saved_cnt_q;
										mv_cnt_q <= saved_cnt_q;
										cont_q   <= sle_pkg::S_RESP;
										if (saved_cnt_q != '0) begin
											st_q <= sle_pkg::S_MV_RD;
										end
									end else begin
										boff_q <= boff_q - 1'b1;
										st_q   <= sle_pkg::S_LOAD;
									end
								end
							end
							default: ;
						endcase
					end else if (ch_c == sle_pkg::CH_ESC) begin
						count_q     <= '0;
						cursor_q    <= '0;
						saved_cnt_q <= '0;
						browse_q    <= 1'b0;
						shift_q     <= 1'b0;
						caps_q      <= 1'b0;
					end else if (ch_c == sle_pkg::CH_LF) begin
						if (count_q != '0) begin
							hhead_q <= (hhead_q == HW'(sle_pkg::HISTORY_DEPTH - 1)) ?
								'0 : hhead_q + 1'b1;
							if (hfill_q < FW'(sle_pkg::HISTORY_DEPTH)) begin
								hfill_q <= hfill_q + 1'b1;
							end
							mv_cnt_q <= count_q;
							cont_q   <= sle_pkg::S_EMIT_RD;
							st_q     <= sle_pkg::S_MV_RD;
						end
						count_q     <= '0;
						cursor_q    <= '0;
						saved_cnt_q <= '0;
						browse_q    <= 1'b0;
						shift_q     <= 1'b0;
						caps_q      <= 1'b0;
					end else if (ch_c == sle_pkg::CH_BS) begin
						if (cursor_q != '0) begin
							mv_cnt_q <= count_q - cursor_q;
							count_q  <= count_q - 1'b1;
							cursor_q <= cursor_q - 1'b1;
							cont_q   <= sle_pkg::S_RESP;
							if (count_q != cursor_q) begin
								st_q <= sle_pkg::S_MV_RD;
							end
						end
					end else if (ch_c >= sle_pkg::CH_SPACE && ch_c != sle_pkg::CH_DEL &&
							count_q < lim_c) begin
						// open a gap at the cursor, then drop the character in
						mv_cnt_q <= count_q - cursor_q;
						cont_q   <= sle_pkg::S_PUT;
						st_q <= (count_q == cursor_q) ? sle_pkg::S_PUT : sle_pkg::S_MV_RD;
					end
				end
				sle_pkg::S_LOAD: begin
					count_q  <= load_n_c;
					cursor_q <= load_n_c;
					mv_cnt_q <= load_n_c;
					cont_q   <= sle_pkg::S_RESP;
					st_q <= (load_n_c == '0) ? sle_pkg::S_RESP : sle_pkg::S_MV_RD;
				end
				sle_pkg::S_MV_RD: begin
					st_q <= sle_pkg::S_MV_WR;
				end
				sle_pkg::S_MV_WR: begin
					if (mv_cnt_q == AW'(1)) begin
						mv_cnt_q <= (cont_q == sle_pkg::S_EMIT_RD) ? emit_n_q : '0;
						st_q <= cont_q;
					end else begin
						mv_cnt_q <= mv_cnt_q - 1'b1;
						st_q <= sle_pkg::S_MV_RD;
					end
				end
				sle_pkg::S_PUT: begin
					count_q  <= count_q + 1'b1;
					cursor_q <= cursor_q + 1'b1;
					st_q     <= sle_pkg::S_RESP;
				end
				sle_pkg::S_EMIT_RD: begin
					st_q <= sle_pkg::S_EMIT_OUT;
				end
				sle_pkg::S_EMIT_OUT: begin
					if (out_free) begin
						mv_cnt_q <= mv_cnt_q - 1'b1;
						st_q <= (mv_cnt_q == AW'(1)) ? sle_pkg::S_IDLE : sle_pkg::S_EMIT_RD;
					end
				end
				sle_pkg::S_RESP: begin
					if (out_free) begin
						st_q <= sle_pkg::S_IDLE;
					end
				end
			endcase
		end
	end

	// datapath registers: addresses, latched word, result code
	always_ff @(posedge clk) begin
		unique case (st_q)
			sle_pkg::S_IDLE: begin
				sc_q <= scancode;
			end
			sle_pkg::S_DECODE: begin
				ev_q     <= sle_pkg::EV_NONE;
				ch_q     <= ch_c;
				src_q    <= sle_pkg::M_LINE;
				dst_q    <= sle_pkg::M_LINE;
				emit_n_q <= enter_n_c;
				if (sc_q == sle_pkg::SC_PREFIX || sc_q[7] ||
						sc_q == sle_pkg::SC_LSHIFT || sc_q == sle_pkg::SC_RSHIFT ||
						sc_q == sle_pkg::SC_CAPS) begin
					ev_q <= sle_pkg::EV_NONE;
				end else if (ext_q) begin
					case (sc_q)
						sle_pkg::SC_LEFT, sle_pkg::SC_HOME: begin
							if (cursor_q != '0) begin
								ev_q <= sle_pkg::EV_EDIT;
							end
						end
						sle_pkg::SC_RIGHT: begin
							if (cursor_q < count_q) begin
								ev_q <= sle_pkg::EV_EDIT;
							end
						end
						sle_pkg::SC_END: begin
							if (cursor_q != count_q) begin
								ev_q <= sle_pkg::EV_EDIT;
							end
						end
						sle_pkg::SC_DEL: begin
							rd_idx_q <= cursor_q + 1'b1;
							wr_idx_q <= cursor_q;
							mv_up_q  <= 1'b1;
							if (cursor_q < count_q) begin
								ev_q <= sle_pkg::EV_EDIT;
							end
						end
						sle_pkg::SC_UP: begin
							rd_idx_q <= '0;
							wr_idx_q <= '0;
							mv_up_q  <= 1'b1;
							dst_q    <= sle_pkg::M_SAVED;
							if (hfill_q != '0 && (!browse_q ||
									{1'b0, boff_q} < FW'(hfill_q - 1'b1))) begin
								ev_q <= sle_pkg::EV_EDIT;
							end
						end
						sle_pkg::SC_DOWN: begin
							rd_idx_q <= '0;
							wr_idx_q <= '0;
							mv_up_q  <= 1'b1;
							src_q    <= sle_pkg::M_SAVED;
							if (browse_q) begin
								ev_q <= sle_pkg::EV_EDIT;
							end
						end
						default: ;
					endcase
				end else if (ch_c == sle_pkg::CH_ESC) begin
					ev_q <= sle_pkg::EV_CANCEL;
				end else if (ch_c == sle_pkg::CH_LF) begin
					rd_idx_q <= '0;
					wr_idx_q <= '0;
					mv_up_q  <= 1'b1;
					dst_q    <= sle_pkg::M_HIST;
					slot_q   <= hhead_q;
					ev_q     <= sle_pkg::EV_EMPTY;
					if (count_q != '0) begin
						hlen_q[hhead_q] <= count_q;
					end
				end else if (ch_c == sle_pkg::CH_BS) begin
					rd_idx_q <= cursor_q;
					wr_idx_q <= cursor_q - 1'b1;
					mv_up_q  <= 1'b1;
					if (cursor_q != '0) begin
						ev_q <= sle_pkg::EV_EDIT;
					end
				end else begin
					rd_idx_q <= count_q - 1'b1;
					wr_idx_q <= count_q;
					mv_up_q  <= 1'b0;
					if (ch_c >= sle_pkg::CH_SPACE && ch_c != sle_pkg::CH_DEL &&
							count_q < lim_c) begin
						ev_q <= sle_pkg::EV_EDIT;
					end
				end
			end
			sle_pkg::S_LOAD: begin
				slot_q   <= slot_c;
				src_q    <= sle_pkg::M_HIST;
				dst_q    <= sle_pkg::M_LINE;
				rd_idx_q <= '0;
				wr_idx_q <= '0;
				mv_up_q  <= 1'b1;
			end
			sle_pkg::S_MV_WR: begin
				if (mv_cnt_q == AW'(1) && cont_q == sle_pkg::S_EMIT_RD) begin
					rd_idx_q <= '0;
				end else if (mv_up_q) begin
					rd_idx_q <= rd_idx_q + 1'b1;
					wr_idx_q <= wr_idx_q + 1'b1;
				end else begin
					rd_idx_q <= rd_idx_q - 1'b1;
					wr_idx_q <= wr_idx_q - 1'b1;
				end
			end
			sle_pkg::S_EMIT_OUT: begin
				if (out_free) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
			sle_pkg::S_MV_RD, sle_pkg::S_PUT, sle_pkg::S_EMIT_RD, sle_pkg::S_RESP: ;
		endcase
	end

	// ---------------------------------------------------------------- output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((st_q == sle_pkg::S_EMIT_OUT || st_q == sle_pkg::S_RESP) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == sle_pkg::S_EMIT_OUT && out_free) begin
			out_ev_q  <= sle_pkg::EV_CHAR;
			out_ch_q  <= line_rdata;
			out_cur_q <= cursor_q;
			out_len_q <= count_q;
			last_q    <= (mv_cnt_q == AW'(1));
		end else if (st_q == sle_pkg::S_RESP && out_free) begin
			out_ev_q  <= ev_q;
			out_ch_q  <= '0;
			out_cur_q <= cursor_q;
			out_len_q <= count_q;
			last_q    <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_res   = out_ev_q;
	assign character   = out_ch_q;
	assign cursor_pos  = out_cur_q;
	assign line_length = out_len_q;
	assign last        = last_q;

`ifndef SYNTHESIS
	a_cursor_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == sle_pkg::S_IDLE) |-> (cursor_q <= count_q))
		else $error("cursor beyond line end");

	a_browse_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		browse_q |-> ({1'b0, boff_q} < hfill_q))
		else $error("browse offset outside filled ring");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hfill_q <= FW'(sle_pkg::HISTORY_DEPTH))
		else $error("history fill overflow");

	a_char_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_ev_q == sle_pkg::EV_CHAR) |-> (out_len_q == '0 && out_cur_q == '0))
		else $error("submitted character with live line");
`endif

endmodule
